// ===== hw/rtl/sswrr_pkg.sv =====
// Shared types, constants and helpers for the weighted round-robin server selector.
// Used by the selector cell and the top level; has no dependencies of its own.
package sswrr_pkg;

  // Pool and field geometry.
  localparam int unsigned MAX_SERVERS = 8;
  localparam int unsigned WEIGHT_BITS = 8;
  localparam int unsigned SRV_W       = 3;   // server index field width
  localparam int unsigned CNT_W       = 4;   // server_count register width
  localparam int unsigned LOAD_W      = 16;  // load value width
  localparam int unsigned CW_W        = 13;  // signed current weight width
  localparam int unsigned BYTE_W      = 8;   // stride of the packed weight table
  localparam int unsigned TABLE_W     = 64;  // weight table register width
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned REG_IDX_W   = 2;
  localparam int unsigned SUM_W       = WEIGHT_BITS + $clog2(MAX_SERVERS);

  // Selection modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_RANDOM = 2'd0,
    MODE_RR     = 2'd1,
    MODE_POWER  = 2'd2,
    MODE_WRR    = 2'd3
  } mode_e;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COUNT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHTS = 2'd2;

  // Input commands.
  localparam logic CMD_SELECT = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // Token that walks the chain of cells, one cell per cycle.
  typedef struct packed {
    logic                     valid;
    logic                     wrr;     // add weights on the way through
    logic                     has;     // a best candidate has been seen
    logic signed [CW_W-1:0]   best;
    logic [SRV_W-1:0]         idx;
    logic [SUM_W-1:0]         sum;
    logic [SRV_W-1:0]         first;
    logic [SRV_W-1:0]         second;
    logic [LOAD_W-1:0]        load_a;  // load of the first random index
    logic [LOAD_W-1:0]        load_b;  // load of the second random index
  } tok_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic                  clear;
    logic                  ld_we;
    logic [SRV_W-1:0]      ld_idx;
    logic [LOAD_W-1:0]     ld_val;
    logic                  sub_en;
    logic [SRV_W-1:0]      sub_idx;
    logic [SUM_W-1:0]      sub_val;
  } cell_ctl_t;

  // Clamp a value one bit wider than a current weight into the signed range.
  function automatic logic signed [CW_W-1:0] sat_cw(input logic signed [CW_W:0] v);
    logic signed [CW_W-1:0] r;
    if (v[CW_W] != v[CW_W-1]) begin
      r = v[CW_W] ? {1'b1, {(CW_W-1){1'b0}}} : {1'b0, {(CW_W-1){1'b1}}};
    end else begin
      r = v[CW_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/server_selector_weighted_rr_top.sv =====
// Weighted round-robin server selector: top level with sequencer, registers and cell chain.
// Depends on sswrr_pkg and sswrr_cell.
//
// Each select beat launches a token down a chain of eight cells, one cell per
// cycle. The first cell takes the token at the accepting edge itself. The
// sequencer captures the token from the end of the chain, then registers the
// result once the output register is free. The input is ready for the next
// beat once the result is registered, so a new select is taken only after
// the previous one is through. Update beats write a server's load value and
// give no result. Random and power-of-two modes flag an index outside the
// pool with index_error and return server 0. Smooth weighted mode falls back
// to round robin when all weights in the pool are zero. A write to the mode,
// count or weight register clears the current weights. While a select is in
// flight the input is stalled; a finished result may wait in the output
// register while the next beat is accepted.
module server_selector_weighted_rr_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sswrr_pkg::REG_IDX_W-1:0]   cfg_index_i,
  input  logic [sswrr_pkg::TABLE_W-1:0]     cfg_data_i,
  // Input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [sswrr_pkg::SRV_W-1:0]       target_server_i,
  input  logic [sswrr_pkg::LOAD_W-1:0]      load_value_i,
  input  logic [sswrr_pkg::SRV_W-1:0]       random_first_i,
  input  logic [sswrr_pkg::SRV_W-1:0]       random_second_i,
  // Output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sswrr_pkg::SRV_W-1:0]       chosen_server_o,
  output logic                              index_error_o
);
  import sswrr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e                 state_q, state_d;
  mode_e                  mode_q;
  logic [CNT_W-1:0]       count_q;
  logic [TABLE_W-1:0]     weights_q;
  logic [SRV_W-1:0]       rr_q, rr_d, rr_p;
  tok_t                   res_q, res_d;
  logic                   out_valid_q, out_valid_d;
  logic [SRV_W-1:0]       chosen_q, chosen_d, pick;
  logic                   err_q, err_d, err;
  logic [CNT_W-1:0]       pool;
  logic                   in_beat, out_beat, cfg_beat, start, finish;
  logic                   first_bad, second_bad;
  cell_ctl_t              ctl;
  tok_t                   tok [MAX_SERVERS+1];

  assign cfg_ready_o = 1'b1;
  assign cfg_beat    = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_beat     = in_valid_i && !in_stall_o;
  assign out_beat    = out_valid_q && !out_stall_i;
  assign start       = in_beat && (command_i == CMD_SELECT);
  assign finish      = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Effective pool size: zero acts as one, large counts clamp to the maximum.
  always_comb begin
    if (count_q == '0) begin
      pool = CNT_W'(1);
    end else if (count_q > CNT_W'(MAX_SERVERS)) begin
      pool = CNT_W'(MAX_SERVERS);
    end else begin
      pool = count_q;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_RANDOM;
      count_q   <= CNT_W'(1);
      weights_q <= {(TABLE_W/BYTE_W){8'h01}};
    end else if (cfg_beat) begin
      unique case (cfg_index_i)
        REG_MODE:    mode_q    <= mode_e'(cfg_data_i[MODE_W-1:0]);
        REG_COUNT:   count_q   <= cfg_data_i[CNT_W-1:0];
        REG_WEIGHTS: weights_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // Token launched into the chain on a select beat.
  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = start;
    tok[0].wrr    = (mode_q == MODE_WRR);
    tok[0].first  = random_first_i;
    tok[0].second = random_second_i;
  end

  // Broadcast control to the cells.
  always_comb begin
    ctl         = '0;
    ctl.clear   = cfg_beat && ((cfg_index_i == REG_MODE) || (cfg_index_i == REG_COUNT)
                               || (cfg_index_i == REG_WEIGHTS));
    ctl.ld_we   = in_beat && (command_i == CMD_UPDATE);
    ctl.ld_idx  = target_server_i;
    ctl.ld_val  = load_value_i;
    ctl.sub_en  = finish && (mode_q == MODE_WRR) && (res_q.sum != '0);
    ctl.sub_idx = res_q.idx;
    ctl.sub_val = res_q.sum;
  end

  // The chain of cells.
  for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
    sswrr_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .index_i  (SRV_W'(i)),
      .pool_i   (pool),
      .weight_i (weights_q[i*BYTE_W +: WEIGHT_BITS]),
      .ctl_i    (ctl),
      .tok_i    (tok[i]),
      .tok_o    (tok[i+1])
    );
  end

  // Result selection from the captured token.
  assign rr_p       = ({1'b0, rr_q} < pool) ? rr_q : '0;
  assign first_bad  = !({1'b0, res_q.first} < pool);
  assign second_bad = !({1'b0, res_q.second} < pool);

  always_comb begin
    pick = '0;
    err  = 1'b0;
    rr_d = rr_q;
    case (mode_q)
      MODE_RANDOM: begin
        err  = first_bad;
        pick = first_bad ? '0 : res_q.first;
      end
      MODE_RR: begin
        pick = rr_p;
        rr_d = rr_p + SRV_W'(1);
      end
      MODE_POWER: begin
        err  = first_bad || second_bad;
        if (!err) begin
          pick = (res_q.load_a <= res_q.load_b) ? res_q.first : res_q.second;
        end
      end
      default: begin
        if (res_q.sum == '0) begin
          pick = rr_p;
          rr_d = rr_p + SRV_W'(1);
        end else begin
          pick = res_q.idx;
        end
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_beat;
    chosen_d    = chosen_q;
    err_d       = err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (tok[MAX_SERVERS].valid) begin
          res_d   = tok[MAX_SERVERS];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (finish) begin
          out_valid_d = 1'b1;
          chosen_d    = pick;
          err_d       = err;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      chosen_q    <= '0;
      err_q       <= 1'b0;
      rr_q        <= '0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      chosen_q    <= chosen_d;
      err_q       <= err_d;
      if (finish) begin
        rr_q <= rr_d;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_server_o = chosen_q;
  assign index_error_o   = err_q;

  // A launched token leaves the end of the chain after passing through every cell.
  a_chain_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##8 tok[MAX_SERVERS].valid)
    else $error("token did not leave the chain on time");

  // A delivered server always lies inside the pool.
  a_chosen_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({1'b0, chosen_q} < pool))
    else $error("chosen server outside the pool");

  // An index error always returns server zero.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q) |-> (chosen_q == '0))
    else $error("index error with nonzero server");

  // Only the modes with random indexes can flag an error.
  a_err_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q) |-> ((mode_q == MODE_RANDOM) || (mode_q == MODE_POWER)))
    else $error("index error in a mode without random indexes");

endmodule

// ===== hw/rtl/sswrr_cell.sv =====
// One cell of the selector chain: holds a server's current weight and load value.
// Depends on sswrr_pkg for the token and control structs and the saturation helper.
module sswrr_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [sswrr_pkg::SRV_W-1:0]  index_i,
  input  logic [sswrr_pkg::CNT_W-1:0]  pool_i,
  input  logic [sswrr_pkg::WEIGHT_BITS-1:0] weight_i,
  input  sswrr_pkg::cell_ctl_t         ctl_i,
  input  sswrr_pkg::tok_t              tok_i,
  output sswrr_pkg::tok_t              tok_o
);
  import sswrr_pkg::*;

  logic signed [CW_W-1:0] cw_q, cw_d, cw_new;
  logic [LOAD_W-1:0]      load_q;
  tok_t                   tok_q, tok_d;
  logic                   active;
  logic                   take;
  logic signed [CW_W:0]   add_v, sub_v;

  // A cell only takes part when its server lies inside the pool.
  assign active = {1'b0, index_i} < pool_i;

  // Weight add and pick subtraction, both one bit wider before clamping.
  assign add_v = $signed({cw_q[CW_W-1], cw_q})
               + $signed({{(CW_W+1-WEIGHT_BITS){1'b0}}, weight_i});
  assign sub_v = $signed({cw_q[CW_W-1], cw_q})
               - $signed({{(CW_W+1-SUM_W){1'b0}}, ctl_i.sub_val});

  assign cw_new = (tok_i.valid && tok_i.wrr && active) ? sat_cw(add_v) : cw_q;
  assign take   = tok_i.valid && active && (!tok_i.has || (cw_new > tok_i.best));

  // Update the passing token: running maximum, weight sum and sampled loads.
  always_comb begin
    tok_d = tok_i;
    if (take) begin
      tok_d.has  = 1'b1;
      tok_d.best = cw_new;
      tok_d.idx  = index_i;
    end
    if (tok_i.valid && active) begin
      tok_d.sum = tok_i.sum + {{(SUM_W-WEIGHT_BITS){1'b0}}, weight_i};
    end
    if (tok_i.first == index_i) begin
      tok_d.load_a = load_q;
    end
    if (tok_i.second == index_i) begin
      tok_d.load_b = load_q;
    end
  end

  // Next current weight: clear on configuration, subtract the sum when picked.
  always_comb begin
    cw_d = cw_new;
    if (ctl_i.clear) begin
      cw_d = '0;
    end else if (ctl_i.sub_en && (ctl_i.sub_idx == index_i)) begin
      cw_d = sat_cw(sub_v);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q   <= '0;
      load_q <= '0;
      tok_q  <= '0;
    end else begin
      cw_q  <= cw_d;
      tok_q <= tok_d;
      if (ctl_i.ld_we && (ctl_i.ld_idx == index_i)) begin
        load_q <= ctl_i.ld_val;
      end
    end
  end

  assign tok_o = tok_q;

endmodule
